@@ src/ucs_pkg.sv @@
// ----------------------------------------------------------------------------
// ucs_pkg
// Types, codes and helpers for the endpoint 0 control transfer sequencer.
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam logic [15:0] MAX_TRANSFER = 16'd2048;
    localparam logic [2:0]  PKT_LOG2_MIN = 3'd3;
    localparam logic [2:0]  PKT_LOG2_MAX = 3'd6;
    localparam logic [2:0]  PKT_LOG2_RST = 3'd6;

    typedef enum logic [2:0] {
        MODE_START_IN  = 3'd0,
        MODE_START_OUT = 3'd1,
        MODE_IN_DONE   = 3'd2,
        MODE_OUT_RCVD  = 3'd3,
        MODE_BAD_SETUP = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_DATA_IN    = 3'd1,
        PH_LAST_IN    = 3'd2,
        PH_STATUS_OUT = 3'd3,
        PH_DATA_OUT   = 3'd4,
        PH_LAST_OUT   = 3'd5,
        PH_STATUS_IN  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        HS_NAK   = 2'd0,
        HS_VALID = 2'd1,
        HS_STALL = 2'd2
    } hs_t;

    typedef enum logic [1:0] {
        NT_NONE     = 2'd0,
        NT_SENT     = 2'd1,
        NT_RECEIVED = 2'd2,
        NT_STALLED  = 2'd3
    } notify_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] w_length;
        logic [15:0] reply_length;
        logic [6:0]  rx_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        tx_load;
        logic [15:0] tx_offset;
        logic [6:0]  tx_length;
        logic [15:0] rx_offset;
        logic [6:0]  rx_accepted;
        logic [1:0]  tx_handshake;
        logic [1:0]  rx_handshake;
        logic        status_out_kind;
        logic [1:0]  notify;
    } res_t;

    // Max packet size in bytes, log2 held to the 8..64 range.
    function automatic logic [6:0] pkt_size(input logic [2:0] size_log2);
        logic [2:0] l;
        l = size_log2;
        if (l < PKT_LOG2_MIN) l = PKT_LOG2_MIN;
        if (l > PKT_LOG2_MAX) l = PKT_LOG2_MAX;
        return 7'd1 << l;
    endfunction

endpackage

@@ src/ucs_intf.sv @@
// ----------------------------------------------------------------------------
// ucs channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] w_length;
    logic [15:0] reply_length;
    logic [6:0]  rx_count;

    modport source (output valid, mode, w_length, reply_length, rx_count, input ready);
    modport sink   (input valid, mode, w_length, reply_length, rx_count, output ready);
endinterface

interface ucs_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic        tx_load;
    logic [15:0] tx_offset;
    logic [6:0]  tx_length;
    logic [15:0] rx_offset;
    logic [6:0]  rx_accepted;
    logic [1:0]  tx_handshake;
    logic [1:0]  rx_handshake;
    logic        status_out_kind;
    logic [1:0]  notify;

    modport source (output valid, phase, tx_load, tx_offset, tx_length, rx_offset,
                    rx_accepted, tx_handshake, rx_handshake, status_out_kind, notify,
                    input ready);
    modport sink   (input valid, phase, tx_load, tx_offset, tx_length, rx_offset,
                    rx_accepted, tx_handshake, rx_handshake, status_out_kind, notify,
                    output ready);
endinterface

interface ucs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] packet_size_log2;

    modport source (output valid, packet_size_log2, input ready);
    modport sink   (input valid, packet_size_log2, output ready);
endinterface

@@ src/usb_control_endpoint_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_sequencer_unit
// Endpoint 0 data/status stage sequencer: one event in, one result out.
// ----------------------------------------------------------------------------
// Datapath: the accepted request is held in the input register, then one
//   pass of compare/add logic writes the result register.
// Throughput: one request per cycle while the result side is ready; the result
//   register decouples a stalled consumer, the input register holds one more request.
// Reset: phase idle, counters and offsets zero, handshakes NAK, packet size 64.
module usb_control_endpoint_sequencer_unit
    import ucs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ucs_req_if.sink  req,
    ucs_res_if.source res,
    ucs_cfg_if.sink  cfg
);

    // Input register
    req_t        req_reg;
    logic        req_valid_reg;
    // Result register
    res_t        res_reg;
    res_t        res_next;
    logic        res_valid_reg;
    // Sequencer state
    logic [2:0]  pkt_log2_reg;
    phase_t      stage_reg,      stage_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] send_offset_reg, send_offset_next;
    logic        zero_due_reg,   zero_due_next;
    logic [15:0] req_length_reg, req_length_next;
    hs_t         tx_hs_reg,      tx_hs_next;
    hs_t         rx_hs_reg,      rx_hs_next;
    logic        out_kind_reg,   out_kind_next;

    logic        advance;
    logic [6:0]  pkt;
    logic [15:0] pkt16;
    logic [15:0] reply_min;
    logic [15:0] reply_clamp;
    logic        zero_due_start;
    logic        is_start_in;
    logic [15:0] sp_count;
    logic [15:0] sp_offset;
    logic        sp_zero;
    logic        sp_more;
    logic [15:0] left;
    logic [6:0]  want;
    logic        rx_short;
    logic [15:0] left_after;

    assign advance   = req_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !req_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.mode         <= req.mode;
            req_reg.w_length     <= req.w_length;
            req_reg.reply_length <= req.reply_length;
            req_reg.rx_count     <= req.rx_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_log2_reg <= PKT_LOG2_RST;
        end
        else if (cfg.valid)
        begin
            pkt_log2_reg <= cfg.packet_size_log2;
        end
    end

    // ---- shared datapath ----
    assign pkt   = pkt_size(pkt_log2_reg);
    assign pkt16 = {9'd0, pkt};

    assign reply_min   = (req_reg.reply_length > req_reg.w_length) ?
                         req_reg.w_length : req_reg.reply_length;
    assign reply_clamp = (reply_min > MAX_TRANSFER) ? MAX_TRANSFER : reply_min;
    assign zero_due_start = (reply_clamp != 16'd0) && (reply_clamp < req_reg.w_length) &&
                            ((reply_clamp & (pkt16 - 16'd1)) == 16'd0);

    // Packet send: a start uses the fresh reply, IN done uses the stored count
    assign is_start_in = (req_reg.mode == MODE_START_IN);
    assign sp_count    = is_start_in ? reply_clamp : byte_count_reg;
    assign sp_offset   = is_start_in ? 16'd0 : send_offset_reg;
    assign sp_zero     = is_start_in ? zero_due_start : zero_due_reg;
    assign sp_more     = pkt16 < sp_count;

    // OUT packet intake
    assign left       = (req_length_reg > byte_count_reg) ?
                        (req_length_reg - byte_count_reg) : 16'd0;
    assign want       = (left < pkt16) ? left[6:0] : pkt;
    assign rx_short   = req_reg.rx_count < want;
    assign left_after = left - {9'd0, want};

    always_comb
    begin
        stage_next       = stage_reg;
        byte_count_next  = byte_count_reg;
        send_offset_next = send_offset_reg;
        zero_due_next    = zero_due_reg;
        req_length_next  = req_length_reg;
        tx_hs_next       = tx_hs_reg;
        rx_hs_next       = rx_hs_reg;
        out_kind_next    = out_kind_reg;

        res_next             = '0;
        res_next.notify      = NT_NONE;

        case (req_reg.mode) inside
            MODE_START_IN, MODE_IN_DONE:
            begin
                if (is_start_in)
                begin
                    req_length_next = req_reg.w_length;
                    out_kind_next   = 1'b0;
                end
                tx_hs_next = HS_NAK;
                if (is_start_in || stage_reg == PH_DATA_IN)
                begin
                    res_next.tx_load   = 1'b1;
                    res_next.tx_offset = sp_offset;
                    tx_hs_next         = HS_VALID;
                    if (sp_more)
                    begin
                        res_next.tx_length = pkt;
                        stage_next         = PH_DATA_IN;
                        rx_hs_next         = HS_STALL;
                        send_offset_next   = sp_offset + pkt16;
                        byte_count_next    = sp_count - pkt16;
                        zero_due_next      = sp_zero;
                    end
                    else
                    begin
                        res_next.tx_length = sp_count[6:0];
                        stage_next         = sp_zero ? PH_DATA_IN : PH_LAST_IN;
                        rx_hs_next         = sp_zero ? HS_STALL : HS_NAK;
                        send_offset_next   = 16'd0;
                        zero_due_next      = 1'b0;
                        byte_count_next    = 16'd0;
                    end
                end
                else if (stage_reg == PH_LAST_IN)
                begin
                    stage_next      = PH_STATUS_OUT;
                    out_kind_next   = 1'b1;
                    rx_hs_next      = HS_VALID;
                    res_next.notify = NT_SENT;
                end
                else if (stage_reg == PH_STATUS_IN)
                begin
                    stage_next = PH_IDLE;
                    rx_hs_next = HS_VALID;
                end
                else
                begin
                    stage_next      = PH_IDLE;
                    tx_hs_next      = HS_STALL;
                    rx_hs_next      = HS_STALL;
                    res_next.notify = NT_STALLED;
                end
            end
            MODE_START_OUT:
            begin
                req_length_next  = req_reg.w_length;
                byte_count_next  = 16'd0;
                send_offset_next = 16'd0;
                zero_due_next    = 1'b0;
                out_kind_next    = 1'b0;
                stage_next       = (req_reg.w_length > pkt16) ? PH_DATA_OUT : PH_LAST_OUT;
                tx_hs_next       = HS_STALL;
                rx_hs_next       = HS_VALID;
            end
            MODE_OUT_RCVD:
            begin
                rx_hs_next = HS_NAK;
                if (stage_reg == PH_DATA_OUT || stage_reg == PH_LAST_OUT)
                begin
                    if (rx_short)
                    begin
                        stage_next      = PH_IDLE;
                        tx_hs_next      = HS_STALL;
                        rx_hs_next      = HS_STALL;
                        res_next.notify = NT_STALLED;
                    end
                    else
                    begin
                        res_next.rx_offset   = byte_count_reg;
                        res_next.rx_accepted = want;
                        byte_count_next      = byte_count_reg + {9'd0, want};
                        if (stage_reg == PH_DATA_OUT)
                        begin
                            rx_hs_next = HS_VALID;
                            if (left_after <= pkt16)
                            begin
                                stage_next = PH_LAST_OUT;
                                tx_hs_next = HS_NAK;
                            end
                            else
                            begin
                                tx_hs_next = HS_STALL;
                            end
                        end
                        else
                        begin
                            // Data complete: arm the zero-length status IN
                            res_next.notify  = NT_RECEIVED;
                            res_next.tx_load = 1'b1;
                            tx_hs_next       = HS_VALID;
                            stage_next       = PH_STATUS_IN;
                        end
                    end
                end
                else if (stage_reg == PH_STATUS_OUT)
                begin
                    stage_next    = PH_IDLE;
                    out_kind_next = 1'b0;
                    rx_hs_next    = HS_VALID;
                    tx_hs_next    = HS_NAK;
                end
                else
                begin
                    stage_next      = PH_IDLE;
                    tx_hs_next      = HS_STALL;
                    rx_hs_next      = HS_STALL;
                    res_next.notify = NT_STALLED;
                end
            end
            MODE_BAD_SETUP:
            begin
                stage_next      = PH_IDLE;
                tx_hs_next      = HS_STALL;
                rx_hs_next      = HS_STALL;
                res_next.notify = NT_STALLED;
            end
            default:
            begin
                // Unused codes report the current state
            end
        endcase

        res_next.phase           = stage_next;
        res_next.tx_handshake    = tx_hs_next;
        res_next.rx_handshake    = rx_hs_next;
        res_next.status_out_kind = out_kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= PH_IDLE;
            byte_count_reg  <= 16'd0;
            send_offset_reg <= 16'd0;
            zero_due_reg    <= 1'b0;
            req_length_reg  <= 16'd0;
            tx_hs_reg       <= HS_NAK;
            rx_hs_reg       <= HS_NAK;
            out_kind_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                stage_reg       <= stage_next;
                byte_count_reg  <= byte_count_next;
                send_offset_reg <= send_offset_next;
                zero_due_reg    <= zero_due_next;
                req_length_reg  <= req_length_next;
                tx_hs_reg       <= tx_hs_next;
                rx_hs_reg       <= rx_hs_next;
                out_kind_reg    <= out_kind_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.phase           = res_reg.phase;
    assign res.tx_load         = res_reg.tx_load;
    assign res.tx_offset       = res_reg.tx_offset;
    assign res.tx_length       = res_reg.tx_length;
    assign res.rx_offset       = res_reg.rx_offset;
    assign res.rx_accepted     = res_reg.rx_accepted;
    assign res.tx_handshake    = res_reg.tx_handshake;
    assign res.rx_handshake    = res_reg.rx_handshake;
    assign res.status_out_kind = res_reg.status_out_kind;
    assign res.notify          = res_reg.notify;

    // ---- assertions ----
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.notify == NT_STALLED |->
            res_reg.phase == PH_IDLE && res_reg.tx_handshake == HS_STALL &&
            res_reg.rx_handshake == HS_STALL)
        else $error("stall result without idle phase and STALL handshakes");

    a_data_out_hs: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.phase == PH_DATA_OUT |->
            res_reg.rx_handshake == HS_VALID && res_reg.tx_handshake == HS_STALL)
        else $error("data OUT phase with wrong handshakes");

    a_tx_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.tx_load |-> res_reg.tx_length <= pkt)
        else $error("loaded IN packet longer than max packet size");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg && $stable(req_reg))
        else $error("pending request dropped or changed before processing");

endmodule

@@ tb/usb_control_endpoint_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_sequencer_unit_tb
// Drives endpoint 0 control-transfer events into the sequencer and checks
// every result against a cycle-free model of the transfer phases. A short
// directed table runs first, then mostly well-formed IN and OUT transfers
// with random lengths and some noise, under several packet sizes, with
// random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
module usb_control_endpoint_sequencer_unit_tb;
    import ucs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEMS_PER_SZ = 150;

    typedef struct {
        req_t rq;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ucs_req_if req_bus ();
    ucs_res_if res_bus ();
    ucs_cfg_if cfg_bus ();

    usb_control_endpoint_sequencer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // Endpoint model state
    logic [2:0]  ep_size_log2 = PKT_LOG2_RST;
    phase_t      ep_stage     = PH_IDLE;
    logic [15:0] ep_count     = '0;
    logic [15:0] ep_send_off  = '0;
    logic        ep_zlp       = 1'b0;
    logic [15:0] ep_req_len   = '0;
    hs_t         ep_tx_hs     = HS_NAK;
    hs_t         ep_rx_hs     = HS_NAK;
    logic        ep_out_kind  = 1'b0;

    res_t     pending_results[$];
    dir_row_t dir_rows[$];
    int       errors    = 0;
    int       hold_left = 0;
    int       res_seen  = 0;
    int       quiet     = 0;
    bit       burst     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned max_packet();
        case (ep_size_log2)
            3'd4:    return 16;
            3'd5:    return 32;
            3'd6,
            3'd7:    return 64;
            default: return 8;
        endcase
    endfunction

    // Bytes the next OUT packet must carry, at most one max packet.
    function automatic int unsigned out_want();
        int unsigned left;
        left = (ep_req_len > ep_count) ? ep_req_len - ep_count : 0;
        return (left < max_packet()) ? left : max_packet();
    endfunction

    function automatic void stall_endpoint(inout res_t o);
        ep_rx_hs = HS_STALL;
        ep_tx_hs = HS_STALL;
        ep_stage = PH_IDLE;
        o.notify = NT_STALLED;
    endfunction

    function automatic void load_in_packet(inout res_t o);
        int unsigned p;
        p = max_packet();
        o.tx_load   = 1'b1;
        o.tx_offset = ep_send_off;
        ep_tx_hs    = HS_VALID;
        if (p < ep_count)
        begin
            o.tx_length = 7'(p);
            ep_stage    = PH_DATA_IN;
            ep_rx_hs    = HS_STALL;
            ep_send_off = 16'(ep_send_off + p);
            ep_count    = 16'(ep_count - p);
        end
        else
        begin
            o.tx_length = ep_count[6:0];
            if (ep_zlp)
            begin
                ep_stage = PH_DATA_IN;
                ep_rx_hs = HS_STALL;
            end
            else
            begin
                ep_stage = PH_LAST_IN;
                ep_rx_hs = HS_NAK;
            end
            ep_send_off = '0;
            ep_zlp      = 1'b0;
            ep_count    = '0;
        end
    endfunction

    function automatic bit take_out_packet(input int unsigned rxc, inout res_t o);
        int unsigned want;
        want = out_want();
        if (rxc < want)
        begin
            stall_endpoint(o);
            return 1'b0;
        end
        o.rx_offset   = ep_count;
        o.rx_accepted = 7'(want);
        ep_count      = 16'(ep_count + want);
        return 1'b1;
    endfunction

    function automatic res_t step_endpoint(input req_t r);
        res_t        o;
        int unsigned p;
        int unsigned reply;
        o = '0;
        p = max_packet();
        case (r.mode)
            MODE_START_IN:
            begin
                ep_req_len = r.w_length;
                reply = r.reply_length;
                if (reply > r.w_length) reply = r.w_length;
                if (reply > MAX_TRANSFER) reply = MAX_TRANSFER;
                ep_count    = 16'(reply);
                ep_send_off = '0;
                ep_zlp      = (reply != 0) && (reply < r.w_length) && ((reply & (p - 1)) == 0);
                ep_out_kind = 1'b0;
                load_in_packet(o);
            end
            MODE_START_OUT:
            begin
                ep_req_len  = r.w_length;
                ep_count    = '0;
                ep_send_off = '0;
                ep_zlp      = 1'b0;
                ep_out_kind = 1'b0;
                ep_stage    = (r.w_length > p) ? PH_DATA_OUT : PH_LAST_OUT;
                ep_tx_hs    = HS_STALL;
                ep_rx_hs    = HS_VALID;
            end
            MODE_IN_DONE:
            begin
                ep_tx_hs = HS_NAK;
                if (ep_stage == PH_DATA_IN)
                    load_in_packet(o);
                else if (ep_stage == PH_LAST_IN)
                begin
                    ep_stage    = PH_STATUS_OUT;
                    ep_out_kind = 1'b1;
                    ep_rx_hs    = HS_VALID;
                    o.notify    = NT_SENT;
                end
                else if (ep_stage == PH_STATUS_IN)
                begin
                    ep_stage = PH_IDLE;
                    ep_rx_hs = HS_VALID;
                    ep_tx_hs = HS_NAK;
                end
                else
                    stall_endpoint(o);
            end
            MODE_OUT_RCVD:
            begin
                ep_rx_hs = HS_NAK;
                if (ep_stage == PH_DATA_OUT)
                begin
                    if (take_out_packet(r.rx_count, o))
                    begin
                        if (ep_req_len - ep_count <= p)
                        begin
                            ep_stage = PH_LAST_OUT;
                            ep_tx_hs = HS_NAK;
                        end
                        else
                            ep_tx_hs = HS_STALL;
                        ep_rx_hs = HS_VALID;
                    end
                end
                else if (ep_stage == PH_LAST_OUT)
                begin
                    if (take_out_packet(r.rx_count, o))
                    begin
                        o.notify    = NT_RECEIVED;
                        o.tx_load   = 1'b1;
                        o.tx_offset = '0;
                        o.tx_length = '0;
                        ep_tx_hs    = HS_VALID;
                        ep_stage    = PH_STATUS_IN;
                    end
                end
                else if (ep_stage == PH_STATUS_OUT)
                begin
                    ep_stage    = PH_IDLE;
                    ep_out_kind = 1'b0;
                    ep_rx_hs    = HS_VALID;
                    ep_tx_hs    = HS_NAK;
                end
                else
                    stall_endpoint(o);
            end
            MODE_BAD_SETUP:
                stall_endpoint(o);
            default:
                ;
        endcase
        o.phase           = ep_stage;
        o.tx_handshake    = ep_tx_hs;
        o.rx_handshake    = ep_rx_hs;
        o.status_out_kind = ep_out_kind;
        return o;
    endfunction

    function automatic res_t mk_res(input logic [2:0] ph, input logic load,
                                    input logic [15:0] toff, input logic [6:0] tlen,
                                    input logic [15:0] roff, input logic [6:0] racc,
                                    input logic [1:0] txh, input logic [1:0] rxh,
                                    input logic kind, input logic [1:0] nt);
        res_t o;
        o.phase           = ph;
        o.tx_load         = load;
        o.tx_offset       = toff;
        o.tx_length       = tlen;
        o.rx_offset       = roff;
        o.rx_accepted     = racc;
        o.tx_handshake    = txh;
        o.rx_handshake    = rxh;
        o.status_out_kind = kind;
        o.notify          = nt;
        return o;
    endfunction

    function automatic void add_row(input logic [2:0] m, input logic [15:0] wl,
                                    input logic [15:0] rl, input logic [6:0] rc,
                                    input bit typed = 1'b0, input res_t e = '0);
        dir_row_t row;
        row.rq.mode         = m;
        row.rq.w_length     = wl;
        row.rq.reply_length = rl;
        row.rq.rx_count     = rc;
        row.typed           = typed;
        row.want            = e;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_length(input int unsigned p);
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 4 * p + 8));
    endfunction

    // Follow the transfer in progress most of the time, inject noise otherwise.
    function automatic req_t next_event();
        req_t        r;
        int unsigned p;
        int unsigned want;
        p = max_packet();
        r.mode         = MODE_BAD_SETUP;
        r.w_length     = 16'($urandom);
        r.reply_length = 16'($urandom);
        r.rx_count     = 7'($urandom_range(0, 64));
        if ($urandom_range(0, 9) == 0)
        begin
            r.mode = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0)
                r.rx_count = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 1) == 0)
            begin
                r.w_length     = pick_length(p);
                r.reply_length = pick_length(p);
            end
            return r;
        end
        case (ep_stage)
            PH_IDLE:
            begin
                r.w_length = pick_length(p);
                if ($urandom_range(0, 1) == 0)
                begin
                    r.mode = MODE_START_IN;
                    case ($urandom_range(0, 2))
                        0:       r.reply_length = 16'($urandom);
                        1:       r.reply_length = 16'(p * $urandom_range(0, 4));
                        default: r.reply_length = 16'($urandom_range(0, 4 * p + 8));
                    endcase
                end
                else
                    r.mode = MODE_START_OUT;
            end
            PH_DATA_IN, PH_LAST_IN, PH_STATUS_IN:
                r.mode = MODE_IN_DONE;
            PH_STATUS_OUT:
            begin
                r.mode = MODE_OUT_RCVD;
                if ($urandom_range(0, 3) != 0)
                    r.rx_count = '0;
            end
            PH_DATA_OUT, PH_LAST_OUT:
            begin
                r.mode = MODE_OUT_RCVD;
                want = out_want();
                r.rx_count = 7'(want);
                if ($urandom_range(0, 3) == 0)
                    r.rx_count = 7'(want + $urandom_range(0, 64 - want));
            end
            default:
                r.mode = MODE_BAD_SETUP;
        endcase
        return r;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input req_t r, input bit typed = 1'b0, input res_t e = '0);
        int   gap;
        res_t predicted;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.mode         <= r.mode;
        req_bus.w_length     <= r.w_length;
        req_bus.reply_length <= r.reply_length;
        req_bus.rx_count     <= r.rx_count;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predicted = step_endpoint(r);
        pending_results.push_back(typed ? e : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_packet_size(input logic [2:0] v);
        cfg_bus.valid            <= 1'b1;
        cfg_bus.packet_size_log2 <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        ep_size_log2 = v;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (a !== e)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    // Result side: ready driven at the falling edge
    initial
    begin
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("phase", e.phase, res_bus.phase);
                check_field("tx_load", e.tx_load, res_bus.tx_load);
                check_field("tx_offset", e.tx_offset, res_bus.tx_offset);
                check_field("tx_length", e.tx_length, res_bus.tx_length);
                check_field("rx_offset", e.rx_offset, res_bus.rx_offset);
                check_field("rx_accepted", e.rx_accepted, res_bus.rx_accepted);
                check_field("tx_handshake", e.tx_handshake, res_bus.tx_handshake);
                check_field("rx_handshake", e.rx_handshake, res_bus.rx_handshake);
                check_field("status_out_kind", e.status_out_kind, res_bus.status_out_kind);
                check_field("notify", e.notify, res_bus.notify);
            end
            res_seen++;
            hold_left = burst ? 0 : $urandom_range(0, 7);
            // Hold off long enough for the request side to back up
            if (res_seen == 400)
                hold_left = 300;
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] sizes[$];
        req_t       r;
        int         n;

        rst_n                <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.mode         <= '0;
        req_bus.w_length     <= '0;
        req_bus.reply_length <= '0;
        req_bus.rx_count     <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.packet_size_log2 <= PKT_LOG2_RST;

        // Directed part, packet size 64 from reset
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_STALLED));
        add_row(MODE_BAD_SETUP, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_STALLED));
        add_row(3'd5, 16'h1234, 16'h4321, 7'd33, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_NONE));
        add_row(MODE_START_IN, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_LAST_IN, 1, 0, 0, 0, 0, HS_VALID, HS_NAK, 0, NT_NONE));
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_STATUS_OUT, 0, 0, 0, 0, 0, HS_NAK, HS_VALID, 1, NT_SENT));
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_NAK, HS_VALID, 0, NT_NONE));
        add_row(MODE_START_IN, 16'hFFFF, 16'hFFFF, 7'd0, 1'b1,
                mk_res(PH_DATA_IN, 1, 0, 64, 0, 0, HS_VALID, HS_STALL, 0, NT_NONE));
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0);
        add_row(MODE_START_IN, 16'd200, 16'd128, 7'd0);
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0);
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0);
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd64);
        add_row(MODE_START_IN, 16'd10, 16'd100, 7'd0);
        add_row(MODE_START_OUT, 16'd100, 16'd0, 7'd0);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd64);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd64);
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0);
        add_row(MODE_START_OUT, 16'd0, 16'd0, 7'd0);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd0);
        add_row(MODE_START_OUT, 16'hFFFF, 16'd0, 7'd0);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd64);
        add_row(MODE_IN_DONE, 16'd0, 16'd0, 7'd0, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_STALLED));
        add_row(MODE_START_OUT, 16'd20, 16'd0, 7'd0);
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd5, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_STALLED));
        add_row(3'd7, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_NONE));
        add_row(MODE_OUT_RCVD, 16'd0, 16'd0, 7'd64, 1'b1,
                mk_res(PH_IDLE, 0, 0, 0, 0, 0, HS_STALL, HS_STALL, 0, NT_STALLED));

        sizes = '{3'd3, 3'd0, 3'd7, 3'd4, 3'd5, 3'd6, 3'd3};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        foreach (sizes[s])
        begin
            drain_results();
            write_packet_size(sizes[s]);
            n = 0;
            while (n < ITEMS_PER_SZ)
            begin
                burst = ((n / 50) % 3) == 2;
                r = next_event();
                send_request(r);
                // unused modes do not count toward the item budget
                if (r.mode <= MODE_BAD_SETUP)
                    n++;
            end
            burst = 1'b0;
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
